FILE: rtl/spq_pkg.sv
// Shared widths and codes of the sorted priority queue.
// No dependencies; both interfaces and the queue import it.
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

  // Widths of the request and response fields.
  localparam int ACTION_W = 3;
  localparam int KEY_W    = 32;
  localparam int PRIO_W   = 2;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 5;

  // Action codes carried by a request.
  localparam logic [ACTION_W-1:0] ACT_INSERT = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_POP    = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_PEEK   = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_REMOVE = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_COUNT  = 3'd4;

  // Status codes carried by a response.
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_MISSING = 2'd3;

endpackage

`default_nettype wire

FILE: rtl/spq_req_if.sv
// Request channel of the sorted priority queue: valid, ready and payload.
// Depends on spq_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface spq_req_if;
  import spq_pkg::*;

  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [KEY_W-1:0]    entry_key;
  logic [PRIO_W-1:0]   priority_req;

  modport source (output valid, action, entry_key, priority_req, input ready);
  modport sink   (input valid, action, entry_key, priority_req, output ready);

endinterface

`default_nettype wire

FILE: rtl/spq_rsp_if.sv
// Response channel of the sorted priority queue: valid, ready and payload.
// Depends on spq_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface spq_rsp_if;
  import spq_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [KEY_W-1:0]    out_key;
  logic [PRIO_W-1:0]   out_priority;
  logic [OCC_W-1:0]    occupancy;

  modport source (output valid, status, out_key, out_priority, occupancy, input ready);
  modport sink   (input valid, status, out_key, out_priority, occupancy, output ready);

endinterface

`default_nettype wire

FILE: rtl/sorted_priority_queue.sv
// Sorted priority queue: sequencer over one slot RAM held in priority order.
// Depends on spq_pkg, spq_req_if, spq_rsp_if and spq_ram.
//
// Usage:
//   req carries one request: insert, pop, peek, remove by key or count.
//   rsp returns exactly one response per request, in request order.
//   A request is taken only while the sequencer is idle; one request is in
//   work at a time. The response sits in an output register, so a finished
//   response may wait on rsp while the next request is taken and worked on.
//   Count, unused codes and refused actions go straight to the response;
//   pop and peek read the head entry; an insert into an empty queue writes
//   slot zero at once, else it walks back from the tail past each entry of
//   lower priority; a remove searches from the head for the key and moves
//   the entries behind it up. Entries move at one per cycle through the
//   single RAM write port.
//   Reset empties the queue at once; slot contents are never cleared and are
//   only used where they hold entries. A stalled rsp holds the response and
//   keeps the sequencer from emitting the next one until it is taken.
`timescale 1ns / 1ps
`default_nettype none

module sorted_priority_queue #(
  parameter int QUEUE_DEPTH   = 16,
  parameter int KEY_BITS      = 32,
  parameter int PRIORITY_BITS = 2
) (
  input  wire logic clk,
  input  wire logic rst,
  spq_req_if.sink   req,
  spq_rsp_if.source rsp
);
  import spq_pkg::*;

  localparam int IDX_W  = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W  = CNT_W + 1;
  localparam int WORD_W = KEY_BITS + PRIORITY_BITS;

  localparam logic [CNT_W-1:0] CNT_ZERO = '0;
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_TWO  = CNT_W'(2);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  typedef enum logic [6:0] {
    S_IDLE      = 7'b0000001,
    S_HEAD      = 7'b0000010,
    S_INS_WALK  = 7'b0000100,
    S_INS_PLACE = 7'b0001000,
    S_RM_SEARCH = 7'b0010000,
    S_RM_SHIFT  = 7'b0100000,
    S_EMIT      = 7'b1000000
  } state_t;

  // Physical slot of the entry that lies off places behind base.
  function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] base,
                                               input logic [CNT_W-1:0] off);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(off);
    if (sum >= SUM_W'(QUEUE_DEPTH)) begin
      sum = sum - SUM_W'(QUEUE_DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

  state_t                   state, state_next;
  logic [IDX_W-1:0]         head, head_next;
  logic [CNT_W-1:0]         count, count_next;
  logic [CNT_W-1:0]         pos, pos_next;
  logic [KEY_BITS-1:0]      op_key, op_key_next;
  logic [PRIORITY_BITS-1:0] op_prio, op_prio_next;
  logic                     op_pop, op_pop_next;
  logic [STATUS_W-1:0]      res_status, res_status_next;
  logic [KEY_W-1:0]         res_key, res_key_next;
  logic [PRIO_W-1:0]        res_prio, res_prio_next;

  logic                     out_valid;
  logic [STATUS_W-1:0]      out_status;
  logic [KEY_W-1:0]         out_key;
  logic [PRIO_W-1:0]        out_prio;
  logic [OCC_W-1:0]         out_occ;
  logic                     out_load;

  logic                     in_fire;
  logic [KEY_BITS-1:0]      key_in;
  logic [PRIORITY_BITS-1:0] prio_in;

  logic                     rd_en, wr_en;
  logic [CNT_W-1:0]         rd_pos, wr_pos;
  logic [IDX_W-1:0]         rd_addr, wr_addr;
  logic [WORD_W-1:0]        rd_data, wr_data;
  logic [KEY_BITS-1:0]      rd_key;
  logic [PRIORITY_BITS-1:0] rd_prio;

  // Handshake and request fields cut or widened to the stored widths.
  assign req.ready = (state == S_IDLE);
  assign in_fire   = req.valid && req.ready;
  assign key_in    = KEY_BITS'(req.entry_key);
  assign prio_in   = PRIORITY_BITS'(req.priority_req);

  // Slot storage: each word holds a key above its priority.
  assign rd_addr = slot_of(head, rd_pos);
  assign wr_addr = slot_of(head, wr_pos);
  assign rd_key  = rd_data[WORD_W-1:PRIORITY_BITS];
  assign rd_prio = rd_data[PRIORITY_BITS-1:0];

  spq_ram #(
    .WIDTH(WORD_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_slots (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // Sequencer: decodes a request, walks the slots and stages the response.
  always_comb begin
    state_next      = state;
    head_next       = head;
    count_next      = count;
    pos_next        = pos;
    op_key_next     = op_key;
    op_prio_next    = op_prio;
    op_pop_next     = op_pop;
    res_status_next = res_status;
    res_key_next    = res_key;
    res_prio_next   = res_prio;
    rd_en           = 1'b0;
    rd_pos          = pos;
    wr_en           = 1'b0;
    wr_pos          = pos;
    wr_data         = rd_data;
    out_load        = 1'b0;

    case (state)
      S_IDLE: begin
        if (in_fire) begin
          op_key_next     = key_in;
          op_prio_next    = prio_in;
          op_pop_next     = (req.action == ACT_POP);
          res_status_next = ST_OK;
          res_key_next    = '0;
          res_prio_next   = '0;
          state_next      = S_EMIT;
          case (req.action)
            ACT_INSERT: begin
              if (count == CNT_FULL) begin
                res_status_next = ST_FULL;
              end else if (count == CNT_ZERO) begin
                wr_en      = 1'b1;
                wr_pos     = CNT_ZERO;
                wr_data    = {key_in, prio_in};
                count_next = count + CNT_ONE;
              end else begin
                pos_next   = count;
                rd_en      = 1'b1;
                rd_pos     = count - CNT_ONE;
                state_next = S_INS_WALK;
              end
            end
            ACT_POP, ACT_PEEK: begin
              if (count == CNT_ZERO) begin
                res_status_next = ST_EMPTY;
              end else begin
                rd_en      = 1'b1;
                rd_pos     = CNT_ZERO;
                state_next = S_HEAD;
              end
            end
            ACT_REMOVE: begin
              if (count == CNT_ZERO) begin
                res_status_next = ST_EMPTY;
              end else begin
                rd_en      = 1'b1;
                rd_pos     = CNT_ZERO;
                pos_next   = CNT_ZERO;
                state_next = S_RM_SEARCH;
              end
            end
            default: begin
              // Count and unused codes only report the occupancy.
            end
          endcase
        end
      end

      // Head entry has arrived; a pop also retires it.
      S_HEAD: begin
        res_key_next  = KEY_W'(rd_key);
        res_prio_next = PRIO_W'(rd_prio);
        if (op_pop) begin
          count_next = count - CNT_ONE;
          head_next  = (count == CNT_ONE) ? '0 : slot_of(head, CNT_ONE);
        end
        state_next = S_EMIT;
      end

      // Entry at pos-1 is on the read port; move it up or settle here.
      S_INS_WALK: begin
        wr_en  = 1'b1;
        wr_pos = pos;
        if (rd_prio >= op_prio) begin
          wr_data    = {op_key, op_prio};
          count_next = count + CNT_ONE;
          state_next = S_EMIT;
        end else begin
          pos_next = pos - CNT_ONE;
          if (pos == CNT_ONE) begin
            state_next = S_INS_PLACE;
          end else begin
            rd_en  = 1'b1;
            rd_pos = pos - CNT_TWO;
          end
        end
      end

      // New entry becomes the head.
      S_INS_PLACE: begin
        wr_en      = 1'b1;
        wr_pos     = pos;
        wr_data    = {op_key, op_prio};
        count_next = count + CNT_ONE;
        state_next = S_EMIT;
      end

      // Entry at pos is on the read port; the next one is fetched meanwhile.
      S_RM_SEARCH: begin
        rd_en  = 1'b1;
        rd_pos = pos + CNT_ONE;
        if (rd_key == op_key) begin
          if (pos + CNT_ONE == count) begin
            count_next = count - CNT_ONE;
            if (count == CNT_ONE) begin
              head_next = '0;
            end
            state_next = S_EMIT;
          end else begin
            state_next = S_RM_SHIFT;
          end
        end else if (pos + CNT_ONE == count) begin
          res_status_next = ST_MISSING;
          state_next      = S_EMIT;
        end else begin
          pos_next = pos + CNT_ONE;
        end
      end

      // Entry at pos+1 is on the read port; it closes the gap at pos.
      S_RM_SHIFT: begin
        wr_en  = 1'b1;
        wr_pos = pos;
        if (pos + CNT_TWO < count) begin
          rd_en    = 1'b1;
          rd_pos   = pos + CNT_TWO;
          pos_next = pos + CNT_ONE;
        end else begin
          count_next = count - CNT_ONE;
          state_next = S_EMIT;
        end
      end

      // Hand the response to the output register once it is free.
      S_EMIT: begin
        if (!out_valid || rsp.ready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      count <= '0;
    end else begin
      state <= state_next;
      head  <= head_next;
      count <= count_next;
    end
  end

  // Working registers of the request in progress.
  always_ff @(posedge clk) begin
    pos        <= pos_next;
    op_key     <= op_key_next;
    op_prio    <= op_prio_next;
    op_pop     <= op_pop_next;
    res_status <= res_status_next;
    res_key    <= res_key_next;
    res_prio   <= res_prio_next;
  end

  // Output register of the response channel.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status <= res_status;
      out_key    <= res_key;
      out_prio   <= res_prio;
      out_occ    <= OCC_W'(count);
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.status       = out_status;
  assign rsp.out_key      = out_key;
  assign rsp.out_priority = out_prio;
  assign rsp.occupancy    = out_occ;

`ifndef SYNTHESIS
  // The queue never holds more than its depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_FULL)
    else $error("entry count exceeds queue depth");

  // An empty queue keeps its head at slot zero.
  a_empty_head: assert property (@(posedge clk) disable iff (rst)
    (count == CNT_ZERO) |-> (head == '0))
    else $error("head moved while queue empty");

  // Once a request is taken the sequencer is busy in the next cycle.
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> (state != S_IDLE))
    else $error("sequencer idle right after taking a request");

  // Slots are only written while a request is in work.
  a_write_in_work: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state != S_EMIT) && (in_fire || (state != S_IDLE)))
    else $error("slot write outside a request");
`endif

endmodule

`default_nettype wire

FILE: rtl/spq_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module spq_ram #(
  parameter int WIDTH = 34,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, registered.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire
